// ===== src/cdp_pkg.sv =====
// Shared widths, face codes and the front-end stage payload type for the cube-map lookup.
package cdp_pkg;

	localparam int DIR_W  = 16;
	localparam int MAG_W  = 16;
	localparam int NUM_W  = 17;
	localparam int TILE_W = 13;
	localparam int FACE_W = 3;
	localparam int COL_W  = 14;
	localparam int ROW_W  = 13;

	localparam int COL_MAX = 16383;
	localparam int ROW_MAX = 8191;

	localparam logic [TILE_W-1:0] TILE_RESET = 13'd512;

	localparam logic [FACE_W-1:0] FACE_NY = 3'd0;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PX = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd5;

	// face choice plus numerators and the common denominator 2*m
	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic              invalid;
		logic [NUM_W-1:0]  num_col;
		logic [NUM_W-1:0]  num_row;
		logic [NUM_W-1:0]  den;
	} front_t;

endpackage

// ===== src/cdp_cfg_if.sv =====
// Configuration write channel carrying the tile size.
interface cdp_cfg_if import cdp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TILE_W-1:0] tile_size;

	modport source (output valid, output tile_size, input ready);
	modport sink (input valid, input tile_size, output ready);
endinterface

// ===== src/cdp_dir_if.sv =====
// Input channel carrying one direction vector.
interface cdp_dir_if import cdp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== src/cdp_pix_if.sv =====
// Output channel carrying the face and atlas pixel position.
interface cdp_pix_if import cdp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FACE_W-1:0] face;
	logic [COL_W-1:0]  pixel_col;
	logic [ROW_W-1:0]  pixel_row;
	logic              invalid;

	modport source (output valid, output face, output pixel_col, output pixel_row,
		output invalid, input ready);
	modport sink (input valid, input face, input pixel_col, input pixel_row,
		input invalid, output ready);
endinterface

// ===== src/cdp_front.sv =====
// Front end: major axis and face selection, then numerators and denominator.
module cdp_front import cdp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic signed [DIR_W-1:0] dir_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output front_t                  out_data
);

	logic [DIR_W:0]     sx, sy, sz;
	logic [DIR_W:0]     nx, ny, nz;
	logic [MAG_W-1:0]   ax, ay, az;
	logic               x_pos, y_pos, z_pos, zero;
	logic [FACE_W-1:0]  sel_face;
	logic [MAG_W-1:0]   sel_m;
	logic [DIR_W:0]     sel_uc, sel_vc;

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	logic [FACE_W-1:0]  face_s1;
	logic               inv_s1;
	logic [MAG_W-1:0]   m_s1;
	logic [DIR_W:0]     uc_s1, vc_s1;
	logic [DIR_W+1:0]   diff_col, sum_row;
	front_t             front_s2;

	// 17-bit two's complement keeps the negation of full-scale negative exact
	assign sx = {dir_x[DIR_W-1], dir_x};
	assign sy = {dir_y[DIR_W-1], dir_y};
	assign sz = {dir_z[DIR_W-1], dir_z};
	assign nx = -sx;
	assign ny = -sy;
	assign nz = -sz;
	assign ax = dir_x[DIR_W-1] ? nx[MAG_W-1:0] : sx[MAG_W-1:0];
	assign ay = dir_y[DIR_W-1] ? ny[MAG_W-1:0] : sy[MAG_W-1:0];
	assign az = dir_z[DIR_W-1] ? nz[MAG_W-1:0] : sz[MAG_W-1:0];
	assign x_pos = !dir_x[DIR_W-1] && (dir_x != '0);
	assign y_pos = !dir_y[DIR_W-1] && (dir_y != '0);
	assign z_pos = !dir_z[DIR_W-1] && (dir_z != '0);
	assign zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

	always_comb begin
		sel_face = FACE_PX;
		sel_m = ax;
		sel_uc = nz;
		sel_vc = sy;
		if (ax >= ay && ax >= az) begin
			sel_m = ax;
			sel_uc = nz;
			if (x_pos) begin
				sel_vc = sy;
				sel_face = FACE_PX;
			end else begin
				sel_vc = ny;
				sel_face = FACE_NX;
			end
		end else if (ay >= ax && ay >= az) begin
			sel_m = ay;
			sel_uc = nz;
			if (y_pos) begin
				sel_vc = nx;
				sel_face = FACE_PY;
			end else begin
				sel_vc = sx;
				sel_face = FACE_NY;
			end
		end else begin
			sel_m = az;
			sel_vc = sy;
			if (z_pos) begin
				sel_uc = sx;
				sel_face = FACE_PZ;
			end else begin
				sel_uc = nx;
				sel_face = FACE_NZ;
			end
		end
	end

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			face_s1 <= sel_face;
			inv_s1 <= zero;
			m_s1 <= sel_m;
			uc_s1 <= sel_uc;
			vc_s1 <= sel_vc;
		end
	end

	// m - vc and m + uc both lie in 0..2m
	assign diff_col = {2'b00, m_s1} - {vc_s1[DIR_W], vc_s1};
	assign sum_row = {2'b00, m_s1} + {uc_s1[DIR_W], uc_s1};

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			front_s2.face <= face_s1;
			front_s2.invalid <= inv_s1;
			front_s2.num_col <= diff_col[NUM_W-1:0];
			front_s2.num_row <= sum_row[NUM_W-1:0];
			front_s2.den <= {m_s1, 1'b0};
		end
	end

	assign out_valid = v_s2;
	assign out_data = front_s2;

endmodule

// ===== src/cdp_div.sv =====
// Scaling by the tile size and a restoring divider, one quotient bit per stage, two lanes.
module cdp_div import cdp_pkg::*; #(
	parameter int TW = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  front_t            in_data,
	input  logic [TW-1:0]     tile,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [FACE_W-1:0] face,
	output logic              invalid,
	output logic [TW-1:0]     q_col,
	output logic [TW-1:0]     q_row
);

	localparam int QW = TW;
	localparam int NW = TW + NUM_W;

	logic              v_s    [QW+1];
	logic              rdy    [QW+2];
	logic [NW-1:0]     rc_s   [QW+1];
	logic [NW-1:0]     rr_s   [QW+1];
	logic [QW-1:0]     qc_s   [QW+1];
	logic [QW-1:0]     qr_s   [QW+1];
	logic [NUM_W-1:0]  den_s  [QW+1];
	logic [FACE_W-1:0] face_s [QW+1];
	logic              inv_s  [QW+1];
	logic [NW-1:0]     prod_col, prod_row;

	assign rdy[QW+1] = out_ready;
	assign in_ready = rdy[0];

	// stage 0: dividends tile*num
	assign prod_col = tile * in_data.num_col;
	assign prod_row = tile * in_data.num_row;
	assign rdy[0] = !v_s[0] || rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rc_s[0] <= prod_col;
			rr_s[0] <= prod_row;
			qc_s[0] <= '0;
			qr_s[0] <= '0;
			den_s[0] <= in_data.den;
			face_s[0] <= in_data.face;
			inv_s[0] <= in_data.invalid;
		end
	end

	// quotient never exceeds the tile size, so QW bits cover it
	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int B = QW - k;
		logic [NW-1:0] trial;
		logic          take_c, take_r;

		assign trial = NW'(den_s[k-1]) << B;
		assign take_c = rc_s[k-1] >= trial;
		assign take_r = rr_s[k-1] >= trial;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rc_s[k] <= take_c ? rc_s[k-1] - trial : rc_s[k-1];
				rr_s[k] <= take_r ? rr_s[k-1] - trial : rr_s[k-1];
				qc_s[k] <= take_c ? (qc_s[k-1] | (QW'(1) << B)) : qc_s[k-1];
				qr_s[k] <= take_r ? (qr_s[k-1] | (QW'(1) << B)) : qr_s[k-1];
				den_s[k] <= den_s[k-1];
				face_s[k] <= face_s[k-1];
				inv_s[k] <= inv_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign face = face_s[QW];
	assign invalid = inv_s[QW];
	assign q_col = qc_s[QW];
	assign q_row = qr_s[QW];

endmodule

// ===== src/cubemap_direction_to_pixel_unit.sv =====
// Top level of the cube-map direction to atlas pixel lookup.
// Takes one direction per clock when not stalled and returns its cube face and
// its pixel in a 3x2 face atlas, one result per direction, in order. The path
// is two front-end stages, one multiply stage, one divider stage per quotient
// bit, and the output register, with TW = clog2(MAX_TILE+1). The divider lanes
// are fully pipelined, so throughput is one transfer per clock while the output
// is not stalled; empty stages close up behind a stalled output. The tile
// size is clamped to MAX_TILE and should be written only while no direction
// is in flight. An all-zero vector gives invalid = 1 with zero position.
module cubemap_direction_to_pixel_unit import cdp_pkg::*; #(
	parameter int MAX_TILE = 4096
) (
	input logic        clk,
	input logic        arst_n,
	cdp_cfg_if.sink    cfg,
	cdp_dir_if.sink    dir,
	cdp_pix_if.source  pix
);

	localparam int TW = $clog2(MAX_TILE + 1);
	localparam int SW = TW + 2;

	logic [TILE_W-1:0] tile_q;
	logic [TW-1:0]     tile_sat;

	logic              fr_valid, fr_ready;
	front_t            fr_data;

	logic              dv_valid, dv_ready;
	logic [FACE_W-1:0] dv_face;
	logic              dv_invalid;
	logic [TW-1:0]     dv_qcol, dv_qrow;

	logic [SW-1:0]     base_col, base_row, sum_col, sum_row, dec_col, dec_row;
	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;

	logic              pix_valid_q;
	logic [FACE_W-1:0] face_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              inv_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= TILE_RESET;
		end else if (cfg.valid) begin
			tile_q <= cfg.tile_size;
		end
	end

	always_comb begin
		if (32'(tile_q) > MAX_TILE) begin
			tile_sat = TW'(MAX_TILE);
		end else begin
			tile_sat = TW'(tile_q);
		end
	end

	cdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dir.valid),
		.in_ready  (dir.ready),
		.dir_x     (dir.dir_x),
		.dir_y     (dir.dir_y),
		.dir_z     (dir.dir_z),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_data  (fr_data)
	);

	cdp_div #(
		.TW (TW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.tile      (tile_sat),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.face      (dv_face),
		.invalid   (dv_invalid),
		.q_col     (dv_qcol),
		.q_row     (dv_qrow)
	);

	// tile offsets: column by face mod 3, row by lower/upper half
	always_comb begin
		case (dv_face)
			FACE_NY, FACE_NZ: base_col = '0;
			FACE_PY, FACE_PX: base_col = SW'(tile_sat);
			FACE_PZ, FACE_NX: base_col = SW'(tile_sat) << 1;
			default:          base_col = '0;
		endcase
		base_row = (dv_face > FACE_PZ) ? SW'(tile_sat) : '0;
		sum_col = base_col + SW'(dv_qcol);
		sum_row = base_row + SW'(dv_qrow);
		dec_col = sum_col - SW'(1);
		dec_row = sum_row - SW'(1);

		// a sum of zero would give -1: clamp to the atlas edge
		if (dv_invalid || sum_col == '0) begin
			col_d = '0;
		end else if (32'(dec_col) > COL_MAX) begin
			col_d = COL_W'(COL_MAX);
		end else begin
			col_d = COL_W'(dec_col);
		end
		if (dv_invalid || sum_row == '0) begin
			row_d = '0;
		end else if (32'(dec_row) > ROW_MAX) begin
			row_d = ROW_W'(ROW_MAX);
		end else begin
			row_d = ROW_W'(dec_row);
		end
	end

	assign dv_ready = !pix_valid_q || pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (dv_ready) begin
			pix_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready) begin
			face_q <= dv_invalid ? FACE_NY : dv_face;
			col_q <= col_d;
			row_q <= row_d;
			inv_q <= dv_invalid;
		end
	end

	assign pix.valid = pix_valid_q;
	assign pix.face = face_q;
	assign pix.pixel_col = col_q;
	assign pix.pixel_row = row_q;
	assign pix.invalid = inv_q;

endmodule

// ===== sim/cubemap_direction_to_pixel_unit_test.sv =====
// Self-checking testbench for the cube-map direction to atlas pixel lookup.
`timescale 1ns / 100ps

module cubemap_direction_to_pixel_unit_test;
	import cdp_pkg::*;

	localparam longint TILE_LIMIT = 4096;

	typedef struct packed {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] z;
	} dir_t;

	typedef struct {
		logic [FACE_W-1:0] face;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              invalid;
	} pixel_t;

	typedef enum int {VEC_FULL, VEC_TIE, VEC_EXTREME, VEC_SMALL} vec_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cdp_cfg_if cfg_bus ();
	cdp_dir_if dir_bus ();
	cdp_pix_if pix_bus ();

	cubemap_direction_to_pixel_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.dir    (dir_bus),
		.pix    (pix_bus)
	);

	pixel_t            pixel_expected[$];
	logic [TILE_W-1:0] tile_model = TILE_RESET;
	int                src_idle_pct = 0;
	int                snk_idle_pct = 0;
	int                hold_left = 0;
	int                mismatch_count = 0;

	always #6 clk = ~clk;

	initial begin
		cfg_bus.valid = 1'b0;
		cfg_bus.tile_size = '0;
		dir_bus.valid = 1'b0;
		dir_bus.dir_x = '0;
		dir_bus.dir_y = '0;
		dir_bus.dir_z = '0;
		pix_bus.ready = 1'b0;
	end

	// max(0, base + floor(t*num/den) - 1), saturated at lim
	function automatic longint atlas_coord(longint base, longint t, longint num, longint den,
		longint lim);
		longint r;
		r = base + (t * num) / den - 1;
		if (r < 0)
			r = 0;
		if (r > lim)
			r = lim;
		return r;
	endfunction

	function automatic pixel_t predict_pixel(dir_t d, logic [TILE_W-1:0] tile);
		longint x, y, z, ax, ay, az, t, m, uc, vc, fidx;
		pixel_t p;
		x = d.x;
		y = d.y;
		z = d.z;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		t = tile;
		if (t > TILE_LIMIT)
			t = TILE_LIMIT;
		p.face = '0;
		p.col = '0;
		p.row = '0;
		p.invalid = 1'b0;
		if (ax == 0 && ay == 0 && az == 0) begin
			p.invalid = 1'b1;
			return p;
		end
		if (ax >= ay && ax >= az) begin
			m = ax;
			uc = -z;
			if (x > 0) begin
				vc = y;
				p.face = FACE_PX;
			end else begin
				vc = -y;
				p.face = FACE_NX;
			end
		end else if (ay >= az) begin
			m = ay;
			uc = -z;
			if (y > 0) begin
				vc = -x;
				p.face = FACE_PY;
			end else begin
				vc = x;
				p.face = FACE_NY;
			end
		end else begin
			m = az;
			vc = y;
			if (z > 0) begin
				uc = x;
				p.face = FACE_PZ;
			end else begin
				uc = -x;
				p.face = FACE_NZ;
			end
		end
		fidx = p.face;
		p.col = COL_W'(atlas_coord(t * (fidx % 3), t, m - vc, 2 * m, COL_MAX));
		p.row = ROW_W'(atlas_coord((fidx > 2) ? t : 0, t, m + uc, 2 * m, ROW_MAX));
		return p;
	endfunction

	function automatic logic signed [DIR_W-1:0] pick_extreme();
		case ($urandom_range(4))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	function automatic dir_t random_direction();
		dir_t d;
		vec_kind_t kind;
		int r, m, pair;
		logic signed [DIR_W-1:0] a, b, c;
		r = $urandom_range(99);
		if (r < 55)
			kind = VEC_FULL;
		else if (r < 75)
			kind = VEC_TIE;
		else if (r < 90)
			kind = VEC_EXTREME;
		else
			kind = VEC_SMALL;
		case (kind)
			VEC_FULL: begin
				d.x = DIR_W'($urandom);
				d.y = DIR_W'($urandom);
				d.z = DIR_W'($urandom);
			end
			VEC_TIE: begin
				// two components share the largest magnitude
				m = $urandom_range(1, 32767);
				a = DIR_W'($urandom_range(1) ? m : -m);
				b = DIR_W'($urandom_range(1) ? m : -m);
				c = DIR_W'(int'($urandom_range(0, 2 * m)) - m);
				pair = $urandom_range(2);
				d.x = (pair == 2) ? c : a;
				d.y = (pair == 0) ? b : ((pair == 1) ? c : b);
				d.z = (pair == 0) ? c : ((pair == 1) ? b : a);
			end
			VEC_EXTREME: begin
				d.x = pick_extreme();
				d.y = pick_extreme();
				d.z = pick_extreme();
			end
			default: begin
				d.x = DIR_W'(int'($urandom_range(0, 8)) - 4);
				d.y = DIR_W'(int'($urandom_range(0, 8)) - 4);
				d.z = DIR_W'(int'($urandom_range(0, 8)) - 4);
			end
		endcase
		return d;
	endfunction

	function automatic logic [TILE_W-1:0] random_tile();
		case ($urandom_range(9))
			0: return TILE_W'($urandom_range(1, 16));
			1: return TILE_W'($urandom_range(4097, 8191));
			default: return TILE_W'($urandom_range(1, 4096));
		endcase
	endfunction

	task automatic send_direction(input dir_t d);
		while ($urandom_range(99) < src_idle_pct) begin
			dir_bus.valid <= 1'b0;
			@(posedge clk);
		end
		dir_bus.valid <= 1'b1;
		dir_bus.dir_x <= d.x;
		dir_bus.dir_y <= d.y;
		dir_bus.dir_z <= d.z;
		@(posedge clk);
		while (!dir_bus.ready)
			@(posedge clk);
		pixel_expected.push_back(predict_pixel(d, tile_model));
	endtask

	task automatic send_xyz(input int x, input int y, input int z);
		dir_t d;
		d.x = DIR_W'(x);
		d.y = DIR_W'(y);
		d.z = DIR_W'(z);
		send_direction(d);
	endtask

	task automatic drain_results();
		dir_bus.valid <= 1'b0;
		while (pixel_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// only called with the pipeline empty
	task automatic write_tile(input logic [TILE_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.tile_size <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		tile_model = value;
		cfg_bus.valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_bus.valid === 1'b1 && pix_bus.ready) begin
			if (pixel_expected.size() == 0) begin
				$display("%0t: unexpected result face %0d col %0d row %0d invalid %0d",
					$time, pix_bus.face, pix_bus.pixel_col, pix_bus.pixel_row,
					pix_bus.invalid);
				mismatch_count++;
			end else begin
				want = pixel_expected.pop_front();
				if (pix_bus.face !== want.face) begin
					$display("%0t: face expected %0d actual %0d", $time, want.face,
						pix_bus.face);
					mismatch_count++;
				end
				if (pix_bus.pixel_col !== want.col) begin
					$display("%0t: pixel_col expected %0d actual %0d", $time, want.col,
						pix_bus.pixel_col);
					mismatch_count++;
				end
				if (pix_bus.pixel_row !== want.row) begin
					$display("%0t: pixel_row expected %0d actual %0d", $time, want.row,
						pix_bus.pixel_row);
					mismatch_count++;
				end
				if (pix_bus.invalid !== want.invalid) begin
					$display("%0t: invalid expected %0d actual %0d", $time, want.invalid,
						pix_bus.invalid);
					mismatch_count++;
				end
			end
		end
	end

	// output ready, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			pix_bus.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			pix_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic test_directed();
		send_xyz(0, 0, 0);
		send_xyz(32767, 0, 0);
		send_xyz(-32768, 0, 0);
		send_xyz(0, 32767, 0);
		send_xyz(0, -32768, 0);
		send_xyz(0, 0, 32767);
		send_xyz(0, 0, -32768);
		send_xyz(20000, 20000, 20000);
		send_xyz(-100, 100, 5);
		send_xyz(0, -500, 500);
		// m + u = 0 on the Y faces: row truncates to -1 and clamps
		send_xyz(0, -1000, 1000);
		send_xyz(0, 1000, 1000);
		send_xyz(-32768, -32768, -32768);
		send_xyz(32767, -32768, 0);
		send_xyz(-32768, 32767, 32767);
		send_xyz(1, 0, 0);
		send_xyz(0, 0, -1);
		send_xyz(-1, 1, -1);
		send_xyz(-1, -1, -1);
		send_xyz(12000, -32768, 32767);
		send_xyz(-32767, 32767, -32768);
		send_xyz(300, -200, 32767);
		drain_results();
	endtask

	task automatic test_tile_extremes();
		logic [TILE_W-1:0] tiles[5];
		tiles = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097};
		foreach (tiles[i]) begin
			write_tile(tiles[i]);
			send_xyz(32767, 32767, -32768);
			send_xyz(-32768, 0, 32767);
			send_xyz(0, 1000, 1000);
			send_xyz(0, 0, 0);
			repeat (16) send_direction(random_direction());
			drain_results();
		end
	endtask

	task automatic test_random(input int count, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int k = 0; k < 3; k++) begin
			drain_results();
			write_tile(random_tile());
			repeat (count / 3) send_direction(random_direction());
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 10;
		@(negedge clk);
		hold_left = 300;
		@(posedge clk);
		repeat (100) send_direction(random_direction());
		drain_results();
	endtask

	task automatic test_drain_pause();
		src_idle_pct = 5;
		snk_idle_pct = 20;
		repeat (40) send_direction(random_direction());
		drain_results();
		repeat (40) send_direction(random_direction());
		drain_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		src_idle_pct = 21;
		snk_idle_pct = 65;
		test_directed();
		test_tile_extremes();
		test_random(510, 21, 65);
		test_random(510, 65, 21);
		test_random(510, 0, 0);
		test_backpressure();
		test_drain_pause();
		write_tile(TILE_RESET);
		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
